// ===== sv/ffea_pkg.sv =====
`default_nettype none
// ============================================================================
// ffea_pkg: shared types and constants of the first-fit extent allocator
// Request and status codes, reset values of the configuration registers and
// the command and status bundles between controller and datapath.
// ============================================================================
package ffea_pkg;

    // Default sizing
    localparam int MAX_EXTENTS_DEF = 64;
    localparam int ADDR_BITS_DEF   = 32;

    // External field widths
    localparam int FIELD_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_START = 2'd2;

    // Configuration reset values
    localparam logic [FIELD_W-1:0] HEAP_BASE_RST    = 32'h0010_0000;
    localparam logic [FIELD_W-1:0] MEM_LIMIT_RST    = 32'h0100_0000;
    localparam logic [FIELD_W-1:0] KERNEL_START_RST = 32'h0000_0000;

    typedef enum logic [1:0] {
        MODE_INIT   = 2'd0,
        MODE_ALLOC  = 2'd1,
        MODE_FREE   = 2'd2,
        MODE_RESIZE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_SCAN_NEXT,
        OP_SCAN_RST,
        OP_A_TAKE,
        OP_A_FAIL,
        OP_F_BAD,
        OP_F_MERGE_LO,
        OP_F_MERGE_HI,
        OP_F_APPEND,
        OP_F_INS,
        OP_R_SHRINK_HIT,
        OP_R_INS,
        OP_R_GROW_HIT,
        OP_INS_FULL,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_PUT,
        OP_DEL_RD,
        OP_DEL_WR,
        OP_DEL_FIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_ld;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  scan_end;     // index reached extent count
        logic  fit;          // current extent holds the request
        logic  alloc_empty;  // allocation empties the extent
        logic  free_bad;     // free range check fails
        logic  len_zero;
        logic  free_below;   // block starts below current extent
        logic  prev_touch;   // previous extent ends at block start
        logic  merge_both;   // merged lower extent reaches current one
        logic  above_touch;  // current extent starts at block end
        logic  full;
        logic  rs_before;    // current extent starts below resize target
        logic  rs_hit;       // current extent starts at resize target
        logic  shrink;
        logic  grow_fit;
        logic  grow_empty;
        logic  del_more;
        logic  ins_more;
        logic  st_ok;
        logic  out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/first_fit_extent_allocator_core.sv =====
`default_nettype none
// ============================================================================
// first_fit_extent_allocator_core: first-fit free-extent allocator
// Address-sorted free extent table with init, allocate, free and resize.
// ============================================================================
// One request is taken at a time and gives one result. The extent table sits
// in a single-port-read memory with a registered read, so a table walk reads
// each extent visited and an insert or delete shift reads and then writes
// each extent moved. The worst case is a growing resize that falls back to
// free plus allocate: it walks the table up to three times and may shift it
// twice. The next request is taken as soon as the result is in the output
// register.
module first_fit_extent_allocator_core
    import ffea_pkg::*;
#(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FIELD_W-1:0]   cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           mode,
    input  wire logic [FIELD_W-1:0]   block_offset,
    input  wire logic [FIELD_W-1:0]   block_length,
    input  wire logic [FIELD_W-1:0]   request_size,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [FIELD_W-1:0]        granted_offset,
    output logic [FIELD_W-1:0]        granted_length,
    output logic [1:0]                status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    ffea_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Table and registers
    ffea_datapath #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mode           (mode),
        .block_offset   (block_offset),
        .block_length   (block_length),
        .request_size   (request_size),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted_offset (granted_offset),
        .granted_length (granted_length),
        .status         (status)
    );

endmodule
`default_nettype wire

// ===== sv/ffea_datapath.sv =====
`default_nettype none
// ============================================================================
// ffea_datapath: extent table, request registers and result registers
// Holds the extent memory (one write port, one registered read port), the
// scan/shift index, configuration registers and the output register.
// ============================================================================
module ffea_datapath
    import ffea_pkg::*;
#(
    parameter int MAX_EXTENTS = MAX_EXTENTS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dp_cmd_t              cmd,
    output dp_stat_t                  stat,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FIELD_W-1:0]   cfg_data,
    input  wire logic [1:0]           mode,
    input  wire logic [FIELD_W-1:0]   block_offset,
    input  wire logic [FIELD_W-1:0]   block_length,
    input  wire logic [FIELD_W-1:0]   request_size,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [FIELD_W-1:0]        granted_offset,
    output logic [FIELD_W-1:0]        granted_length,
    output logic [1:0]                status
);

    localparam int AW = ADDR_BITS;
    localparam int IW = $clog2(MAX_EXTENTS);
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int EW = 2 * AW;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EXTENTS);

    // Extent memory: {start, size}
    logic [EW-1:0] ram [MAX_EXTENTS];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_s;
    logic [AW-1:0] rd_z;

    // Configuration
    logic [AW-1:0] hb_reg;
    logic [AW-1:0] ml_reg;
    logic [AW-1:0] ks_reg;

    // Control state
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic          prev_ok_reg;
    status_t       st_reg;
    logic          out_valid_reg;

    // Payload state
    mode_t         mode_reg;
    logic [AW-1:0] off_reg;
    logic [AW-1:0] len_reg;
    logic [AW-1:0] rsz_reg;
    logic [AW-1:0] prev_s_reg;
    logic [AW-1:0] prev_z_reg;
    logic [AW-1:0] prev_end_reg;
    logic [CW-1:0] pos_reg;
    logic [AW-1:0] ins_s_reg;
    logic [AW-1:0] ins_z_reg;
    logic [AW-1:0] go_reg;
    logic [AW-1:0] gl_reg;
    logic [FIELD_W-1:0] out_go_reg;
    logic [FIELD_W-1:0] out_gl_reg;
    status_t            out_st_reg;

    // Derived values
    logic [AW-1:0] blk_end;
    logic [AW-1:0] dsh;
    logic [AW-1:0] dgr;
    logic          hb_lt_ml;
    logic [CW-1:0] rd_idx;
    logic [IW-1:0] rd_addr;
    logic          we;
    logic [CW-1:0] wa;
    logic [EW-1:0] wd;

    assign {rd_s, rd_z} = rd_data_reg;
    assign blk_end  = off_reg + len_reg;
    assign dsh      = len_reg - rsz_reg;
    assign dgr      = rsz_reg - len_reg;
    assign hb_lt_ml = hb_reg < ml_reg;

    // Status toward the controller
    always_comb
    begin
        stat.mode        = mode_reg;
        stat.scan_end    = idx_reg == count_reg;
        stat.fit         = rd_z >= rsz_reg;
        stat.alloc_empty = (rd_z == rsz_reg) && (rsz_reg != '0);
        stat.free_bad    = (off_reg < ks_reg) || (len_reg > ~off_reg) ||
                           (blk_end >= ml_reg);
        stat.len_zero    = len_reg == '0;
        stat.free_below  = off_reg < rd_s;
        stat.prev_touch  = prev_ok_reg && (prev_end_reg == off_reg);
        stat.merge_both  = (prev_end_reg + len_reg) == rd_s;
        stat.above_touch = rd_s == blk_end;
        stat.full        = count_reg >= MAX_CNT;
        stat.rs_before   = rd_s < blk_end;
        stat.rs_hit      = (idx_reg != count_reg) && (rd_s == blk_end);
        stat.shrink      = rsz_reg < len_reg;
        stat.grow_fit    = dgr <= rd_z;
        stat.grow_empty  = rd_z == dgr;
        stat.del_more    = ({1'b0, idx_reg} + 1'b1) < {1'b0, count_reg};
        stat.ins_more    = idx_reg > pos_reg;
        stat.st_ok       = st_reg == ST_OK;
        stat.out_busy    = out_valid_reg && out_stall;
    end

    // Read address
    always_comb
    begin
        case (cmd.op)
            OP_INS_RD: rd_idx = idx_reg - 1'b1;
            OP_DEL_RD: rd_idx = idx_reg + 1'b1;
            default:   rd_idx = idx_reg;
        endcase
    end
    assign rd_addr = rd_idx[IW-1:0];

    // Write port
    always_comb
    begin
        we = 1'b0;
        wa = idx_reg;
        wd = rd_data_reg;
        case (cmd.op)
            OP_INIT:
            begin
                we = hb_lt_ml;
                wa = '0;
                wd = {hb_reg, ml_reg - hb_reg};
            end
            OP_A_TAKE:
            begin
                we = 1'b1;
                wd = {rd_s + rsz_reg, rd_z - rsz_reg};
            end
            OP_F_MERGE_LO:
            begin
                we = 1'b1;
                wa = idx_reg - 1'b1;
                wd = {prev_s_reg,
                      prev_z_reg + len_reg + (stat.merge_both ? rd_z : '0)};
            end
            OP_F_MERGE_HI:
            begin
                we = 1'b1;
                wd = {off_reg, rd_z + len_reg};
            end
            OP_F_APPEND:
            begin
                we = 1'b1;
                wa = idx_reg - 1'b1;
                wd = {prev_s_reg, prev_z_reg + len_reg};
            end
            OP_R_SHRINK_HIT:
            begin
                we = 1'b1;
                wd = {rd_s - dsh, rd_z + dsh};
            end
            OP_R_GROW_HIT:
            begin
                we = 1'b1;
                wd = {rd_s + dgr, rd_z - dgr};
            end
            OP_INS_WR: we = 1'b1;
            OP_INS_PUT:
            begin
                we = 1'b1;
                wa = pos_reg;
                wd = {ins_s_reg, ins_z_reg};
            end
            OP_DEL_WR: we = 1'b1;
            default: ;
        endcase
    end

    // Extent memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram[wa[IW-1:0]] <= wd;
        end
        rd_data_reg <= ram[rd_addr];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_reg <= AW'(HEAP_BASE_RST);
            ml_reg <= AW'(MEM_LIMIT_RST);
            ks_reg <= AW'(KERNEL_START_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEAP_BASE:    hb_reg <= AW'(cfg_data);
                CFG_MEM_LIMIT:    ml_reg <= AW'(cfg_data);
                CFG_KERNEL_START: ks_reg <= AW'(cfg_data);
                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            prev_ok_reg   <= 1'b0;
            st_reg        <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    idx_reg     <= '0;
                    prev_ok_reg <= 1'b0;
                    st_reg      <= ST_OK;
                end
                OP_INIT:
                begin
                    count_reg <= hb_lt_ml ? CW'(1) : '0;
                    st_reg    <= hb_lt_ml ? ST_OK : ST_OOM;
                end
                OP_SCAN_NEXT:
                begin
                    idx_reg     <= idx_reg + 1'b1;
                    prev_ok_reg <= 1'b1;
                end
                OP_SCAN_RST:
                begin
                    idx_reg     <= '0;
                    prev_ok_reg <= 1'b0;
                end
                OP_A_FAIL:   st_reg <= ST_OOM;
                OP_F_BAD:    st_reg <= ST_RANGE;
                OP_F_INS:    idx_reg <= count_reg;
                OP_R_INS:    idx_reg <= count_reg;
                OP_INS_FULL: st_reg <= ST_FULL;
                OP_INS_WR:   idx_reg <= idx_reg - 1'b1;
                OP_INS_PUT:  count_reg <= count_reg + 1'b1;
                OP_DEL_WR:   idx_reg <= idx_reg + 1'b1;
                OP_DEL_FIN:  count_reg <= count_reg - 1'b1;
                default: ;
            endcase

            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                mode_reg <= mode_t'(mode);
                off_reg  <= AW'(block_offset);
                len_reg  <= AW'(block_length);
                rsz_reg  <= AW'(request_size);
                go_reg   <= '0;
                gl_reg   <= '0;
            end
            OP_SCAN_NEXT:
            begin
                prev_s_reg   <= rd_s;
                prev_z_reg   <= rd_z;
                prev_end_reg <= rd_s + rd_z;
            end
            OP_A_TAKE:
            begin
                go_reg <= rd_s;
                gl_reg <= rsz_reg;
            end
            OP_A_FAIL, OP_INS_FULL:
            begin
                go_reg <= '0;
                gl_reg <= '0;
            end
            OP_F_INS:
            begin
                pos_reg   <= idx_reg;
                ins_s_reg <= off_reg;
                ins_z_reg <= len_reg;
            end
            OP_R_INS:
            begin
                pos_reg   <= idx_reg;
                ins_s_reg <= off_reg + rsz_reg;
                ins_z_reg <= dsh;
                go_reg    <= off_reg;
                gl_reg    <= rsz_reg;
            end
            OP_R_SHRINK_HIT, OP_R_GROW_HIT:
            begin
                go_reg <= off_reg;
                gl_reg <= rsz_reg;
            end
            default: ;
        endcase

        if (cmd.out_ld)
        begin
            out_go_reg <= FIELD_W'(go_reg);
            out_gl_reg <= FIELD_W'(gl_reg);
            out_st_reg <= st_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted_offset = out_go_reg;
    assign granted_length = out_gl_reg;
    assign status         = out_st_reg;

    // Table bounds
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("extent count above table depth");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("table index beyond extent count");

    a_ins_put: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_INS_PUT |-> (idx_reg == pos_reg) && (count_reg < MAX_CNT))
        else $error("insert placed at wrong slot or into a full table");

endmodule
`default_nettype wire

// ===== sv/ffea_ctrl.sv =====
`default_nettype none
// ============================================================================
// ffea_ctrl: request sequencer of the first-fit extent allocator
// Walks the extent table, runs the shift loops for insert and delete and
// chains free and allocate for a resize that cannot stay in place.
// ============================================================================
module ffea_ctrl
    import ffea_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_DISPATCH = 18'h00002,
        S_A_RD     = 18'h00004,
        S_A_EV     = 18'h00008,
        S_F_CHK    = 18'h00010,
        S_F_RD     = 18'h00020,
        S_F_EV     = 18'h00040,
        S_R_RD     = 18'h00080,
        S_R_EV     = 18'h00100,
        S_R_DEC    = 18'h00200,
        S_INS_CHK  = 18'h00400,
        S_INS_RD   = 18'h00800,
        S_INS_WR   = 18'h01000,
        S_DEL_CHK  = 18'h02000,
        S_DEL_RD   = 18'h04000,
        S_DEL_WR   = 18'h08000,
        S_FIN      = 18'h10000,
        S_DONE     = 18'h20000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fb_reg;      // resize fallback: allocate after the free
    logic   fb_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fb_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fb_reg    <= fb_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

    // Next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        fb_next    = fb_reg;
        cmd.op     = OP_NONE;
        cmd.out_ld = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    fb_next    = 1'b0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.mode)
                    MODE_INIT:
                    begin
                        cmd.op     = OP_INIT;
                        state_next = S_FIN;
                    end
                    MODE_ALLOC: state_next = S_A_RD;
                    MODE_FREE:  state_next = S_F_CHK;
                    default:    state_next = S_R_RD;
                endcase
            end

            // first-fit scan
            S_A_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.op     = OP_A_FAIL;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_A_EV;
                end
            end
            S_A_EV:
            begin
                if (stat.fit)
                begin
                    cmd.op     = OP_A_TAKE;
                    state_next = stat.alloc_empty ? S_DEL_CHK : S_FIN;
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_A_RD;
                end
            end

            // free: range check, then find the slot
            S_F_CHK:
            begin
                if (stat.free_bad)
                begin
                    cmd.op     = OP_F_BAD;
                    state_next = S_FIN;
                end
                else if (stat.len_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = OP_SCAN_RST;
                    state_next = S_F_RD;
                end
            end
            S_F_RD:
            begin
                if (stat.scan_end)
                begin
                    if (stat.prev_touch)
                    begin
                        cmd.op     = OP_F_APPEND;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.op     = OP_F_INS;
                        state_next = S_INS_CHK;
                    end
                end
                else
                begin
                    state_next = S_F_EV;
                end
            end
            S_F_EV:
            begin
                if (stat.free_below)
                begin
                    if (stat.prev_touch)
                    begin
                        cmd.op     = OP_F_MERGE_LO;
                        state_next = stat.merge_both ? S_DEL_CHK : S_FIN;
                    end
                    else if (stat.above_touch)
                    begin
                        cmd.op     = OP_F_MERGE_HI;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.op     = OP_F_INS;
                        state_next = S_INS_CHK;
                    end
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_F_RD;
                end
            end

            // resize: find the first extent at or above the block end
            S_R_RD:
            begin
                state_next = stat.scan_end ? S_R_DEC : S_R_EV;
            end
            S_R_EV:
            begin
                if (stat.rs_before)
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = S_R_RD;
                end
                else
                begin
                    state_next = S_R_DEC;
                end
            end
            S_R_DEC:
            begin
                if (stat.shrink)
                begin
                    if (stat.rs_hit)
                    begin
                        cmd.op     = OP_R_SHRINK_HIT;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.op     = OP_R_INS;
                        state_next = S_INS_CHK;
                    end
                end
                else if (stat.rs_hit && stat.grow_fit)
                begin
                    cmd.op     = OP_R_GROW_HIT;
                    state_next = stat.grow_empty ? S_DEL_CHK : S_FIN;
                end
                else
                begin
                    fb_next    = 1'b1;
                    state_next = S_F_CHK;
                end
            end

            // insert: shift entries up one slot from the top
            S_INS_CHK:
            begin
                if (stat.full)
                begin
                    cmd.op     = OP_INS_FULL;
                    state_next = S_FIN;
                end
                else if (stat.ins_more)
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.op     = OP_INS_PUT;
                    state_next = S_FIN;
                end
            end
            S_INS_RD:
            begin
                cmd.op     = OP_INS_RD;
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.op     = OP_INS_WR;
                state_next = S_INS_CHK;
            end

            // delete: shift entries down one slot
            S_DEL_CHK:
            begin
                if (stat.del_more)
                begin
                    state_next = S_DEL_RD;
                end
                else
                begin
                    cmd.op     = OP_DEL_FIN;
                    state_next = S_FIN;
                end
            end
            S_DEL_RD:
            begin
                cmd.op     = OP_DEL_RD;
                state_next = S_DEL_WR;
            end
            S_DEL_WR:
            begin
                cmd.op     = OP_DEL_WR;
                state_next = S_DEL_CHK;
            end

            S_FIN:
            begin
                if (fb_reg)
                begin
                    fb_next = 1'b0;
                    if (stat.st_ok)
                    begin
                        cmd.op     = OP_SCAN_RST;
                        state_next = S_A_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== bench/ffea_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// ffea_checker: result predictor and scoreboard for the extent allocator
// Snoops the register port and both item channels, keeps its own copy of the
// free extent table and compares every result item with the predicted grant.
// ============================================================================
module ffea_checker
    import ffea_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [FIELD_W-1:0] cfg_data,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [1:0]         mode,
    input  wire logic [FIELD_W-1:0] block_offset,
    input  wire logic [FIELD_W-1:0] block_length,
    input  wire logic [FIELD_W-1:0] request_size,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [FIELD_W-1:0] granted_offset,
    input  wire logic [FIELD_W-1:0] granted_length,
    input  wire logic [1:0]         status,
    output int                      fail_count,
    output int                      pending,
    output int                      checked
);

    localparam int DEPTH = MAX_EXTENTS_DEF;

    typedef struct {
        logic [31:0] offset;
        logic [31:0] length;
        status_t     st;
    } grant_t;

    // Shadow registers and free extent table
    logic [31:0] heap_lo = HEAP_BASE_RST;
    logic [31:0] mem_top = MEM_LIMIT_RST;
    logic [31:0] free_floor = KERNEL_START_RST;
    logic [31:0] ext_base [DEPTH];
    logic [31:0] ext_len  [DEPTH];
    int          ext_num = 0;
    grant_t      grant_q[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
    end

    function automatic bit tbl_insert(int i, logic [31:0] s, logic [31:0] l);
        if (ext_num >= DEPTH || i > ext_num)
            return 0;
        for (int k = ext_num; k > i; k--)
        begin
            ext_base[k] = ext_base[k-1];
            ext_len[k]  = ext_len[k-1];
        end
        ext_base[i] = s;
        ext_len[i]  = l;
        ext_num++;
        return 1;
    endfunction

    function automatic void tbl_remove(int i);
        if (i >= ext_num)
            return;
        for (int k = i; k + 1 < ext_num; k++)
        begin
            ext_base[k] = ext_base[k+1];
            ext_len[k]  = ext_len[k+1];
        end
        ext_num--;
    endfunction

    function automatic logic [31:0] tail_of(int i);
        return ext_base[i] + ext_len[i];
    endfunction

    // First fit: carve the low part of the first big enough extent
    function automatic status_t take_first_fit(logic [31:0] req,
                                               output logic [31:0] go,
                                               output logic [31:0] gl);
        for (int i = 0; i < ext_num; i++)
        begin
            if (ext_len[i] >= req)
            begin
                go = ext_base[i];
                gl = req;
                ext_base[i] = ext_base[i] + req;
                ext_len[i]  = ext_len[i] - req;
                if (ext_len[i] == 0 && req != 0)
                    tbl_remove(i);
                return ST_OK;
            end
        end
        go = '0;
        gl = '0;
        return ST_OOM;
    endfunction

    // Return a block to the table, merging with its neighbors
    function automatic status_t release_block(logic [31:0] off, logic [31:0] len);
        logic [31:0] stop;
        if (off < free_floor || len > (32'hFFFF_FFFF - off))
            return ST_RANGE;
        stop = off + len;
        if (stop >= mem_top)
            return ST_RANGE;
        if (len == 0)
            return ST_OK;
        for (int i = 0; i < ext_num; i++)
        begin
            if (off < ext_base[i])
            begin
                if (i > 0 && tail_of(i-1) == off)
                begin
                    ext_len[i-1] = ext_len[i-1] + len;
                    if (tail_of(i-1) == ext_base[i])
                    begin
                        ext_len[i-1] = ext_len[i-1] + ext_len[i];
                        tbl_remove(i);
                    end
                    return ST_OK;
                end
                if (ext_base[i] == stop)
                begin
                    ext_base[i] = off;
                    ext_len[i]  = ext_len[i] + len;
                    return ST_OK;
                end
                return tbl_insert(i, off, len) ? ST_OK : ST_FULL;
            end
        end
        if (ext_num > 0 && tail_of(ext_num-1) == off)
        begin
            ext_len[ext_num-1] = ext_len[ext_num-1] + len;
            return ST_OK;
        end
        return tbl_insert(ext_num, off, len) ? ST_OK : ST_FULL;
    endfunction

    // Full request: updates the table and gives the expected grant
    function automatic grant_t predict_grant(mode_t m, logic [31:0] off,
                                             logic [31:0] len, logic [31:0] req);
        grant_t      g;
        logic [31:0] target;
        logic [31:0] diff;
        int          i;
        g.offset = '0;
        g.length = '0;
        g.st     = ST_OK;
        case (m)
            MODE_INIT:
            begin
                ext_num = 0;
                if (heap_lo < mem_top)
                begin
                    ext_base[0] = heap_lo;
                    ext_len[0]  = mem_top - heap_lo;
                    ext_num     = 1;
                end
                else
                    g.st = ST_OOM;
            end
            MODE_ALLOC:
                g.st = take_first_fit(req, g.offset, g.length);
            MODE_FREE:
                g.st = release_block(off, len);
            default:
            begin
                target = off + len;
                i = 0;
                while (i < ext_num && ext_base[i] < target)
                    i++;
                if (req < len)
                begin
                    // shrink: tail goes to the following extent or a new one
                    diff = len - req;
                    if (i < ext_num && ext_base[i] == target)
                    begin
                        ext_base[i] = ext_base[i] - diff;
                        ext_len[i]  = ext_len[i] + diff;
                    end
                    else if (!tbl_insert(i, off + req, diff))
                        g.st = ST_FULL;
                    if (g.st == ST_OK)
                    begin
                        g.offset = off;
                        g.length = req;
                    end
                end
                else
                begin
                    diff = req - len;
                    if (i < ext_num && ext_base[i] == target && diff <= ext_len[i])
                    begin
                        ext_base[i] = ext_base[i] + diff;
                        ext_len[i]  = ext_len[i] - diff;
                        if (ext_len[i] == 0)
                            tbl_remove(i);
                        g.offset = off;
                        g.length = req;
                    end
                    else
                    begin
                        // grow fallback: free, then allocate afresh
                        g.st = release_block(off, len);
                        if (g.st == ST_OK)
                            g.st = take_first_fit(req, g.offset, g.length);
                    end
                end
                if (g.st != ST_OK)
                begin
                    g.offset = '0;
                    g.length = '0;
                end
            end
        endcase
        return g;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, want, got);
        fail_count++;
    endtask

    // Predict on accepted requests, compare on accepted results
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE:    heap_lo    = cfg_data;
                    CFG_MEM_LIMIT:    mem_top    = cfg_data;
                    CFG_KERNEL_START: free_floor = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                grant_q.push_back(predict_grant(mode_t'(mode), block_offset,
                                                block_length, request_size));
            if (out_valid && !out_stall)
            begin
                checked++;
                if (grant_q.size() == 0)
                begin
                    $display("[%0t] result item with no request outstanding", $realtime);
                    fail_count++;
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (granted_offset !== want.offset)
                        report("granted_offset", want.offset, granted_offset);
                    if (granted_length !== want.length)
                        report("granted_length", want.length, granted_length);
                    if (status !== want.st)
                        report("status", 32'(want.st), 32'(status));
                end
            end
            pending = grant_q.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench: stimulus and verdict for first_fit_extent_allocator_core
// Directed corner requests, then mostly well-formed alloc/free/resize traffic
// on blocks that were really granted, over several register settings and
// idle/stall profiles; a side checker predicts and compares every result.
// ============================================================================
module testbench;
    import ffea_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        mode_t       m;
        int          gen;
    } sent_t;

    typedef struct {
        logic [31:0] offset;
        logic [31:0] length;
    } block_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [1:0]           mode;
    logic [FIELD_W-1:0]   block_offset;
    logic [FIELD_W-1:0]   block_length;
    logic [FIELD_W-1:0]   request_size;
    logic                 out_valid;
    logic                 out_stall;
    logic [FIELD_W-1:0]   granted_offset;
    logic [FIELD_W-1:0]   granted_length;
    logic [1:0]           status;

    int fail_count;
    int pending;
    int checked;

    int     idle_pct = 0;
    int     stall_pct = 0;
    int     hold_asked = 0;
    int     hold_done = 0;
    int     hold_left = 0;
    int     quiet = 0;
    int     items = 0;
    int     gen = 0;
    int     max_sz = 4096;
    sent_t  sent_q[$];
    block_t live[$];

    first_fit_extent_allocator_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .block_offset(block_offset),
        .block_length(block_length), .request_size(request_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .granted_offset(granted_offset), .granted_length(granted_length),
        .status(status)
    );

    ffea_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .block_offset(block_offset),
        .block_length(block_length), .request_size(request_size),
        .out_valid(out_valid), .out_stall(out_stall),
        .granted_offset(granted_offset), .granted_length(granted_length),
        .status(status),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stall, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_done < hold_asked)
        begin
            hold_done++;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Track granted blocks so later frees and resizes hit real ones
    always @(posedge clk)
    begin
        sent_t s;
        if (rst_n && out_valid && !out_stall && sent_q.size() > 0)
        begin
            s = sent_q.pop_front();
            if (s.gen == gen && status == ST_OK && granted_length != 0 &&
                (s.m == MODE_ALLOC || s.m == MODE_RESIZE))
                live.push_back('{granted_offset, granted_length});
        end
    end

    // Watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("** first_fit_extent_allocator_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic offer(input mode_t m, input logic [31:0] off,
                         input logic [31:0] len, input logic [31:0] req);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        block_offset <= off;
        block_length <= len;
        request_size <= req;
        do
            @(posedge clk);
        while (in_stall);
        if (m == MODE_INIT)
        begin
            gen++;
            live.delete();
        end
        sent_q.push_back('{m, gen});
        items++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_heap(input logic [31:0] lo, input logic [31:0] top,
                            input logic [31:0] floor_addr);
        longint span;
        drain();
        write_reg(CFG_HEAP_BASE, lo);
        write_reg(CFG_MEM_LIMIT, top);
        write_reg(CFG_KERNEL_START, floor_addr);
        @(posedge clk);
        span = (top > lo) ? (longint'(top) - longint'(lo)) / 256 : 1;
        max_sz = (span < 1) ? 1 : (span > 4096) ? 4096 : int'(span);
        offer(MODE_INIT, $urandom, $urandom, $urandom);
    endtask

    // One random item, mostly allocations or operations on blocks actually granted
    task automatic random_item();
        int     r;
        int     k;
        block_t b;
        logic [31:0] req;
        r = $urandom_range(0, 99);
        if (r < 8)
            offer(mode_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        else if (r < 12)
            offer(MODE_ALLOC, $urandom, $urandom, ($urandom_range(0, 3) == 0) ? 0 : $urandom);
        else if (live.size() == 0 || r < 55)
            offer(MODE_ALLOC, $urandom, $urandom, $urandom_range(1, max_sz));
        else
        begin
            k = $urandom_range(0, live.size() - 1);
            b = live[k];
            live.delete(k);
            if (r < 85)
            begin
                // an occasional misaligned free makes overlapping ranges
                if ($urandom_range(0, 9) == 0)
                    b.offset = b.offset + 1;
                offer(MODE_FREE, b.offset, b.length, $urandom);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    req = $urandom_range(0, b.length);
                else
                    req = b.length + $urandom_range(0, max_sz);
                offer(MODE_RESIZE, b.offset, b.length, req);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_HEAP_BASE;
        cfg_data     = '0;
        in_valid     = 1'b0;
        mode         = MODE_INIT;
        block_offset = '0;
        block_length = '0;
        request_size = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners on the reset settings
        offer(MODE_ALLOC, 0, 0, 0);                       // empty table
        offer(MODE_INIT, 0, 0, 0);
        offer(MODE_ALLOC, 0, 0, 0);                       // zero-size grant
        offer(MODE_ALLOC, 0, 0, 32'h100);
        offer(MODE_ALLOC, 0, 0, 32'h200);
        offer(MODE_ALLOC, 0, 0, 32'h300);
        offer(MODE_FREE, 32'h0010_0100, 32'h200, 0);      // insert
        offer(MODE_FREE, 32'h0010_0000, 32'h100, 0);      // merge with upper
        offer(MODE_RESIZE, 32'h0010_0300, 32'h300, 32'h100);  // shrink hit
        offer(MODE_RESIZE, 32'h0010_0300, 32'h100, 32'h400);  // grow in place
        offer(MODE_RESIZE, 32'h0010_0300, 32'h400, 32'h2000_0000); // fallback oom
        offer(MODE_FREE, 32'hFFFF_FF00, 32'h200, 0);      // wraps address space
        offer(MODE_FREE, 32'h0020_0000, 0, 0);            // zero length
        offer(MODE_FREE, 32'h00FF_FFF0, 32'h10, 0);       // ends at limit
        offer(MODE_ALLOC, 0, 0, 32'hFFFF_FFFF);
        offer(MODE_RESIZE, 32'h00F0_0000, 32'h10, 0);     // shrink, append
        offer(MODE_FREE, 32'h0000_0800, 32'h800, 0);      // insert at the front
        offer(MODE_FREE, 32'h0000_0000, 32'h800, 0);
        offer(MODE_FREE, 32'h00FF_FF00, 32'h10, 0);       // below limit, past all

        // Random traffic over several settings and idle profiles
        for (int set = 0; set < 4; set++)
        begin
            case (set)
                0: set_heap(32'h0000_1000, 32'h0008_0000, 32'h0000_1000);
                1: set_heap(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
                2: set_heap(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
                default: set_heap(32'h0000_0400, 32'h0000_4000, 32'h0000_0000);
            endcase
            if (set == 2)
                offer(MODE_ALLOC, 0, 0, 0);
            for (int n = 0; n < ((set == 2) ? 80 : 240); n++)
            begin
                if (n % 40 == 0)
                begin
                    case ((n / 40 + set) % 4)
                        0: begin idle_pct = 0;  stall_pct = 0;  end
                        1: begin idle_pct = 81; stall_pct = 0;  end
                        2: begin idle_pct = 0;  stall_pct = 81; end
                        default: begin idle_pct = 30; stall_pct = 30; end
                    endcase
                end
                if (n == 100)
                begin
                    // long receiver hold-off while requests keep coming
                    hold_asked++;
                    idle_pct = 0;
                end
                if (n == 150)
                    drain();
                random_item();
            end
        end

        drain();
        repeat (400) @(posedge clk);
        $display("covered %0d requests and %0d checked results over 5 register settings",
                 items, checked);
        $display("idle profiles: none, sender 81%%, receiver 81%%, both 30%%, plus hold-offs");
        if (fail_count == 0)
            $display("** first_fit_extent_allocator_core: PASSED **");
        else
            $display("** first_fit_extent_allocator_core: FAILED **");
        $finish;
    end

endmodule
